### hw/rtl/tcsd_pkg.sv
// ----------------------------------------------------------------------------
// tcsd_pkg
// Shared types and constants for the chunked TLV stream decoder.
// ----------------------------------------------------------------------------
package tcsd_pkg;

   // width of the merged item length counter, saturating at its maximum
   localparam int LEN_BITS = 16;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   // length byte that marks a full chunk, which may be continued by a record of the same type
   localparam logic [7:0] FULL_CHUNK = 8'd255;

   // result queue geometry
   localparam int Q_DEPTH    = 4;
   localparam int Q_IDX_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_CLOSE_BYTE = 2'd1,
      KIND_CLOSE      = 2'd2,
      KIND_ERROR      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  item_type;
      logic [7:0]  value_byte;
      logic [15:0] item_length;
      logic        last_of_run;
   } result_type;

   // results made by one accepted beat, first goes out before second
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [15:0] report_len(input logic [LEN_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [7:0] t,
                                              input logic [7:0] b, input logic [15:0] l);
      result_type r;
      r.kind        = k;
      r.item_type   = t;
      r.value_byte  = b;
      r.item_length = l;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

### hw/rtl/tcsd_step.sv
// ----------------------------------------------------------------------------
// tcsd_step
// Record phase tracking and result generation, one input beat per cycle while accept is high.
// ----------------------------------------------------------------------------
module tcsd_step
   import tcsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       buffer_end,
   output push_type   push
);

   typedef enum logic [1:0] {
      PH_TYPE       = 2'd0,
      PH_LEN        = 2'd1,
      PH_VALUE      = 2'd2,
      PH_AFTER_FULL = 2'd3
   } phase_type;

   phase_type           phase_ff,   phase_in;
   logic [7:0]          type_ff,    type_in;
   logic [7:0]          left_ff,    left_in;
   logic [LEN_BITS-1:0] merged_ff,  merged_in;
   logic                pending_ff, pending_in;

   logic [LEN_BITS-1:0] merged_inc;
   logic [7:0]          left_dec;
   result_type          r0, r1;
   logic [1:0]          n;

   assign merged_inc = (merged_ff == LEN_MAX) ? merged_ff : merged_ff + 1'b1;
   assign left_dec   = left_ff - 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      left_in    = left_ff;
      merged_in  = merged_ff;
      pending_in = pending_ff;
      r0         = '0;
      r1         = '0;
      n          = 2'd0;
      case (phase_ff)
         PH_TYPE: begin
            type_in    = in_byte;
            merged_in  = '0;
            pending_in = 1'b0;
            left_in    = 8'd0;
            phase_in   = PH_LEN;
            if (buffer_end) begin
               r0 = make_result(KIND_ERROR, in_byte, 8'd0, 16'd0);
               n  = 2'd1;
            end
         end
         PH_AFTER_FULL: begin
            if (in_byte == type_ff) begin
               // same type continues the merged item
               phase_in   = PH_LEN;
               pending_in = 1'b0;
               if (buffer_end) begin
                  r0 = make_result(KIND_ERROR, type_ff, 8'd0, 16'd0);
                  n  = 2'd1;
               end
            end else begin
               r0         = make_result(KIND_CLOSE, type_ff, 8'd0, report_len(merged_ff));
               n          = 2'd1;
               type_in    = in_byte;
               merged_in  = '0;
               pending_in = 1'b0;
               left_in    = 8'd0;
               phase_in   = PH_LEN;
               if (buffer_end) begin
                  r1 = make_result(KIND_ERROR, in_byte, 8'd0, 16'd0);
                  n  = 2'd2;
               end
            end
         end
         PH_LEN: begin
            left_in    = in_byte;
            pending_in = (in_byte == FULL_CHUNK);
            if (in_byte == 8'd0) begin
               r0       = make_result(KIND_CLOSE, type_ff, 8'd0, report_len(merged_ff));
               n        = 2'd1;
               phase_in = PH_TYPE;
            end else if (buffer_end) begin
               r0 = make_result(KIND_ERROR, type_ff, 8'd0, 16'd0);
               n  = 2'd1;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            merged_in = merged_inc;
            left_in   = left_dec;
            n         = 2'd1;
            if (left_dec == 8'd0) begin
               if (pending_ff && !buffer_end) begin
                  r0       = make_result(KIND_BYTE, type_ff, in_byte, 16'd0);
                  phase_in = PH_AFTER_FULL;
               end else begin
                  r0       = make_result(KIND_CLOSE_BYTE, type_ff, in_byte,
                                         report_len(merged_inc));
                  phase_in = PH_TYPE;
               end
            end else begin
               r0 = make_result(KIND_BYTE, type_ff, in_byte, 16'd0);
               if (buffer_end) begin
                  r1 = make_result(KIND_ERROR, type_ff, 8'd0, 16'd0);
                  n  = 2'd2;
               end
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
      if (buffer_end) begin
         phase_in = PH_TYPE;
      end
      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = 1'b1;
   end

   assign push.count  = accept ? n : 2'd0;
   assign push.first  = r0;
   assign push.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         type_ff    <= 8'd0;
         left_ff    <= 8'd0;
         merged_ff  <= '0;
         pending_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         type_ff    <= type_in;
         left_ff    <= left_in;
         merged_ff  <= merged_in;
         pending_ff <= pending_in;
      end
   end

`ifndef SYNTH
   // a zero length byte always closes the item with one result
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_LEN && in_byte == 8'd0) |-> (push.count == 2'd1))
      else $error("zero length did not close item");

   // after an end-marked beat the next beat is a type byte
   assert property (@(posedge clock) disable iff (reset)
      (accept && buffer_end) |=> (phase_ff == PH_TYPE))
      else $error("phase not back to type after buffer end");

   // a value beat always passes its byte out
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_VALUE) |-> (push.count != 2'd0 &&
         (push.first.kind == KIND_BYTE || push.first.kind == KIND_CLOSE_BYTE)))
      else $error("value beat without byte result");
`endif

endmodule

### hw/rtl/tcsd_outq.sv
// ----------------------------------------------------------------------------
// tcsd_outq
// Small result queue, takes up to two results a cycle and sends one while out_stall is low.
// ----------------------------------------------------------------------------
module tcsd_outq
   import tcsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room_two,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_res
);

   result_type            entries_ff [Q_DEPTH];
   logic [Q_IDX_BITS-1:0] head_ff,  head_in;
   logic [Q_IDX_BITS-1:0] tail_ff,  tail_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;
   logic [Q_IDX_BITS-1:0] tail_next;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = entries_ff[head_ff];
   assign pop       = out_valid && !out_stall;
   assign room_two  = (count_ff <= Q_CNT_BITS'(Q_DEPTH - 2));
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + Q_IDX_BITS'(push.count);
      count_in = count_ff + Q_CNT_BITS'(push.count) - Q_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[tail_next] <= push.second;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_BITS'(Q_DEPTH))
      else $error("result queue overfilled");

   // a push only lands when two slots are free
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room_two)
      else $error("push without room");

   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("queue count moved without push or pop");
`endif

endmodule

### hw/rtl/tlv_chunked_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tlv_chunked_stream_decoder_top
// Chunked type-length-value stream decoder, one encoded byte per beat.
// ----------------------------------------------------------------------------
// Each request beat carries one byte of a TLV buffer and a flag on the
// buffer's last byte. Full 255-byte chunks followed by a record of the same
// type are merged into one item; value bytes leave with their type, and every
// item is closed with its total length, saturating at 65535. A buffer cut off
// inside a header or a value gives an error result. A byte makes zero, one or
// two response beats. A request beat is taken every cycle while the four-entry
// result queue has two free slots, so the decoder sustains one byte per cycle
// as long as responses drain at least as fast as they are made; a byte's
// responses are registered in the result queue and leave it in order.
module tlv_chunked_stream_decoder_top
   import tcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_item_type,
   output logic [7:0]  rsp_value_byte,
   output logic [15:0] rsp_item_length,
   output logic        rsp_last_of_run
);

   logic       room_two;
   logic       accept;
   push_type   push;
   result_type res;

   assign req_stall = !room_two;
   assign accept    = req_valid && room_two;

   tcsd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .buffer_end (req_buffer_end),
      .push       (push)
   );

   tcsd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (res)
   );

   assign rsp_kind        = res.kind;
   assign rsp_item_type   = res.item_type;
   assign rsp_value_byte  = res.value_byte;
   assign rsp_item_length = res.item_length;
   assign rsp_last_of_run = res.last_of_run;

endmodule

### test/tlv_chunked_stream_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlv_chunked_stream_decoder_top_tb
// Self-checking bench for the chunked TLV stream decoder. TLV buffers are fed
// one byte per beat: short hand-picked buffers first, then full-chunk chains,
// then random buffers (well formed, cut short, or plain noise). A behavioural
// decoder works out every response beat, and a monitor compares the responses
// with them in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tlv_chunked_stream_decoder_top_tb;
   import tcsd_pkg::*;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_VALUE,
      PH_AFTER_FULL
   } dec_phase_type;

   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_BYTES = 250;

   class tlv_decode_board;
      dec_phase_type       phase;
      logic [7:0]          cur_type;
      logic [7:0]          chunk_left;
      logic [LEN_BITS-1:0] merged_len;
      logic                full_pending;
      result_type          due_results[$];
      int unsigned         bad_results;

      function new();
         phase        = PH_TYPE;
         cur_type     = '0;
         chunk_left   = '0;
         merged_len   = '0;
         full_pending = 1'b0;
         bad_results  = 0;
      endfunction

      function logic [15:0] reported_len();
         longint unsigned m;
         m = merged_len;
         return (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
      endfunction

      function void open_item(logic [7:0] t);
         cur_type     = t;
         merged_len   = '0;
         full_pending = 1'b0;
         chunk_left   = '0;
         phase        = PH_LEN;
      endfunction

      function void add_due(kind_type k, logic [7:0] b, logic [15:0] l);
         result_type r;
         r.kind        = k;
         r.item_type   = cur_type;
         r.value_byte  = b;
         r.item_length = l;
         r.last_of_run = 1'b0;
         due_results.push_back(r);
      endfunction

      // notes one accepted request beat and queues the responses it causes
      function void take_byte(logic [7:0] b, logic last);
         int n0;
         n0 = due_results.size();
         case (phase)
            PH_TYPE: begin
               open_item(b);
               if (last) add_due(KIND_ERROR, 8'h00, 16'h0000);
            end
            PH_AFTER_FULL: begin
               if (b == cur_type) begin
                  phase        = PH_LEN;
                  full_pending = 1'b0;
               end else begin
                  // merged item is closed before the new type takes over
                  add_due(KIND_CLOSE, 8'h00, reported_len());
                  open_item(b);
               end
               if (last) add_due(KIND_ERROR, 8'h00, 16'h0000);
            end
            PH_LEN: begin
               chunk_left   = b;
               full_pending = (b == FULL_CHUNK);
               if (b == 8'h00) begin
                  add_due(KIND_CLOSE, 8'h00, reported_len());
                  phase = PH_TYPE;
               end else if (last) begin
                  add_due(KIND_ERROR, 8'h00, 16'h0000);
               end else begin
                  phase = PH_VALUE;
               end
            end
            default: begin
               if (merged_len != LEN_MAX) merged_len++;
               chunk_left--;
               if (chunk_left == 8'h00) begin
                  if (full_pending && !last) begin
                     add_due(KIND_BYTE, b, 16'h0000);
                     phase = PH_AFTER_FULL;
                  end else begin
                     add_due(KIND_CLOSE_BYTE, b, reported_len());
                     phase = PH_TYPE;
                  end
               end else begin
                  add_due(KIND_BYTE, b, 16'h0000);
                  if (last) add_due(KIND_ERROR, 8'h00, 16'h0000);
               end
            end
         endcase
         if (last) phase = PH_TYPE;
         if (due_results.size() > n0) due_results[due_results.size() - 1].last_of_run = 1'b1;
      endfunction

      function void check_result(result_type got);
         result_type want;
         bit         bad;
         if (due_results.size() == 0) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
               $display("%0t: unexpected response kind %0d type %02h byte %02h len %0d last %0b",
                        $time, got.kind, got.item_type, got.value_byte, got.item_length,
                        got.last_of_run);
            return;
         end
         want = due_results.pop_front();
         bad  = (got.kind !== want.kind) || (got.item_type !== want.item_type) ||
                (got.value_byte !== want.value_byte) ||
                (got.item_length !== want.item_length) ||
                (got.last_of_run !== want.last_of_run);
         if (bad) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS) begin
               $display("%0t: response mismatch", $time);
               $display("   want kind %0d type %02h byte %02h len %0d last %0b", want.kind,
                        want.item_type, want.value_byte, want.item_length, want.last_of_run);
               $display("   got  kind %0d type %02h byte %02h len %0d last %0b", got.kind,
                        got.item_type, got.value_byte, got.item_length, got.last_of_run);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_buffer_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_item_type;
   logic [7:0]  rsp_value_byte;
   logic [15:0] rsp_item_length;
   logic        rsp_last_of_run;

   tlv_decode_board board = new();
   logic [7:0]      enc_q[$];
   bit              quiet_tx;
   bit              quiet_rx;

   tlv_chunked_stream_decoder_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_buffer_end  (req_buffer_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_type   (rsp_item_type),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_item_length (rsp_item_length),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 80) return $urandom_range(1, 6);
      return $urandom_range(7, 40);
   endfunction

   function automatic void add_record(input logic [7:0] t, input int unsigned len);
      enc_q.push_back(t);
      enc_q.push_back(8'(len));
      repeat (len) enc_q.push_back(8'($urandom));
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = quiet_tx ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_buffer_end <= last;
      do @(posedge clock); while (req_stall);
      board.take_byte(b, last);
   endtask

   // sends the queued buffer up to and including the byte marked as its end
   task automatic send_buffer(input int stop);
      for (int i = 0; i <= stop; i++) send_beat(enc_q[i], i == stop);
      enc_q.delete();
   endtask

   initial begin : rsp_stall_gen
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = quiet_rx ? 0 : pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind        = kind_type'(rsp_kind);
         got.item_type   = rsp_item_type;
         got.value_byte  = rsp_value_byte;
         got.item_length = rsp_item_length;
         got.last_of_run = rsp_last_of_run;
         board.check_result(got);
      end
   end

   initial begin : stimulus
      int unsigned sel;
      int unsigned sent;
      int unsigned t;
      int          stop;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_buffer_end = 1'b0;
      quiet_tx       = 1'b0;
      quiet_rx       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty item, then a one-byte item closing the buffer, all-ones fields
      enc_q = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF};
      send_buffer(enc_q.size() - 1);
      // cut off after the type byte
      enc_q = '{8'h5A};
      send_buffer(0);
      // cut off after a length byte
      enc_q = '{8'h11, 8'h03};
      send_buffer(1);
      // cut off inside a value
      enc_q = '{8'h22, 8'h04, 8'h00, 8'hA5};
      send_buffer(3);
      // zero length on the last byte
      enc_q = '{8'h81, 8'h00};
      send_buffer(1);
      enc_q = '{8'h7E, 8'h02, 8'h55, 8'hAA, 8'h01, 8'h00};
      send_buffer(5);

      // full chunk closed by an empty record, by another type, and by the buffer end
      add_record(8'h3C, 255);
      add_record(8'h3C, 0);
      add_record(8'h3C, 255);
      add_record(8'hC3, 2);
      add_record(8'h77, 255);
      send_buffer(enc_q.size() - 1);
      // same type after a full chunk, then the buffer ends
      add_record(8'h42, 255);
      enc_q.push_back(8'h42);
      send_buffer(enc_q.size() - 1);
      // other type after a full chunk, then the buffer ends
      add_record(8'h42, 255);
      enc_q.push_back(8'h43);
      send_buffer(enc_q.size() - 1);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         quiet_tx = ($urandom_range(0, 4) == 0);
         quiet_rx = ($urandom_range(0, 4) == 0);
         sel      = $urandom_range(0, 99);
         if (sel < 75) begin
            repeat ($urandom_range(1, 4)) begin
               t = $urandom_range(0, 255);
               if ($urandom_range(0, 39) == 0) begin
                  repeat ($urandom_range(1, 2)) add_record(8'(t), 255);
                  if ($urandom_range(0, 1) == 1) add_record(8'(t), pick_len());
               end else begin
                  add_record(8'(t), pick_len());
               end
            end
            stop = enc_q.size() - 1;
            // a share of the well-formed buffers is cut short
            if (sel >= 55) stop = $urandom_range(0, enc_q.size() - 1);
         end else begin
            repeat ($urandom_range(1, 12)) enc_q.push_back(8'($urandom));
            stop = enc_q.size() - 1;
         end
         sent += stop + 1;
         send_buffer(stop);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      quiet_rx  = 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.bad_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
